// ===== hw/rtl/itoa_pkg.sv =====
// itoa_pkg: shared constants, types and the BCD digit adjust used by the
// signed integer to decimal ASCII block. No dependencies.
package itoa_pkg;

    localparam int         DIGIT_W       = 4;      // one BCD digit
    localparam int         BITS_PER_STEP = 4;      // binary bits folded in per cycle
    localparam logic [7:0] CHAR_ZERO     = 8'd48;  // '0'
    localparam logic [7:0] CHAR_MINUS    = 8'd45;  // '-'
    localparam logic [3:0] DAB_ADJ_MIN   = 4'd5;
    localparam logic [3:0] DAB_ADJ_ADD   = 4'd3;
    localparam logic [3:0] DIGIT_MAX     = 4'd9;

    // Command from the sequencer to the character emitter.
    typedef struct packed {
        logic load;   // take a new digit string this cycle
        logic neg;    // prefix a minus sign
    } emit_cmd_t;

    // Status from the character emitter back to the sequencer.
    typedef struct packed {
        logic busy;    // digits still to go out
        logic finish;  // final character pushed this cycle
    } emit_stat_t;

    // Shift-add-3 correction for one BCD digit.
    function automatic logic [3:0] dab_adjust(input logic [3:0] digit);
        logic [3:0] res;
        res = digit;
        if (digit >= DAB_ADJ_MIN) begin
            res = digit + DAB_ADJ_ADD;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/itoa_dabble.sv =====
// itoa_dabble: iterative binary to BCD converter (double dabble), folding
// BITS_PER_STEP bits per cycle through one shared adjust-and-shift unit.
// Depends on itoa_pkg.
module itoa_dabble #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   start,
    input  logic [VALUE_WIDTH-1:0]                 mag,
    output logic                                   done,
    output logic [NDIG*itoa_pkg::DIGIT_W-1:0]      bcd
);

    localparam int STEP  = itoa_pkg::BITS_PER_STEP;
    localparam int NSTEP = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int PADW  = NSTEP * STEP;
    localparam int BCDW  = NDIG * itoa_pkg::DIGIT_W;
    localparam int CNTW  = $clog2(NSTEP + 1);

    logic [PADW-1:0] bin_reg, bin_next;
    logic [BCDW-1:0] bcd_reg, bcd_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;

    logic [BCDW+PADW-1:0] work;

    // Shared unit: STEP rounds of digit adjust then shift left by one.
    always_comb begin
        work = {bcd_reg, bin_reg};
        for (int b = 0; b < STEP; b++) begin
            for (int d = 0; d < NDIG; d++) begin
                work[PADW + d*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W] =
                    itoa_pkg::dab_adjust(
                        work[PADW + d*itoa_pkg::DIGIT_W +: itoa_pkg::DIGIT_W]);
            end
            work = {work[BCDW+PADW-2:0], 1'b0};
        end
    end

    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = PADW'(mag);
            bcd_next  = '0;
            cnt_next  = CNTW'(NSTEP);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bin_next = work[PADW-1:0];
            bcd_next = work[BCDW+PADW-1:PADW];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// ===== hw/rtl/itoa_emit.sv =====
// itoa_emit: walks a BCD digit string from the top, drops leading zeros and
// drives the character output register. Depends on itoa_pkg.
module itoa_emit #(
    parameter int NDIG = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  itoa_pkg::emit_cmd_t               cmd,
    input  logic [NDIG*itoa_pkg::DIGIT_W-1:0] bcd,
    output itoa_pkg::emit_stat_t              stat,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    output logic                              m_tlast
);

    localparam int DW   = itoa_pkg::DIGIT_W;
    localparam int BCDW = NDIG * DW;
    localparam int LW   = $clog2(NDIG + 1);

    logic [BCDW-1:0] dig_reg, dig_next;
    logic [LW-1:0]   left_reg, left_next;
    logic            sign_reg, sign_next;
    logic            lead_reg, lead_next;
    logic            active_reg, active_next;
    logic            valid_reg, valid_next;
    logic [7:0]      data_reg, data_next;
    logic            last_reg, last_next;

    logic       out_free;
    logic [3:0] top_digit;
    logic       is_final;
    logic       skip;
    logic       push_sign;
    logic       push_dig;

    assign out_free  = !valid_reg || m_tready;
    assign top_digit = dig_reg[BCDW-1 -: DW];
    assign is_final  = (left_reg == LW'(1));
    // leading zero: dropped without a character, may overlap the minus sign
    assign skip      = active_reg && lead_reg && (top_digit == '0) && !is_final;
    assign push_sign = active_reg && sign_reg && out_free;
    assign push_dig  = active_reg && !sign_reg && !skip && out_free;

    always_comb begin
        dig_next    = dig_reg;
        left_next   = left_reg;
        sign_next   = sign_reg;
        lead_next   = lead_reg;
        active_next = active_reg;
        valid_next  = valid_reg && !m_tready;
        data_next   = data_reg;
        last_next   = last_reg;
        if (cmd.load) begin
            dig_next    = bcd;
            left_next   = LW'(NDIG);
            sign_next   = cmd.neg;
            lead_next   = 1'b1;
            active_next = 1'b1;
        end else begin
            if (skip || push_dig) begin
                dig_next  = {dig_reg[BCDW-DW-1:0], {DW{1'b0}}};
                left_next = left_reg - 1'b1;
            end
            if (push_sign) begin
                sign_next  = 1'b0;
                valid_next = 1'b1;
                data_next  = itoa_pkg::CHAR_MINUS;
                last_next  = 1'b0;
            end
            if (push_dig) begin
                lead_next  = 1'b0;
                valid_next = 1'b1;
                data_next  = itoa_pkg::CHAR_ZERO + {4'b0000, top_digit};
                last_next  = is_final;
                if (is_final) begin
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
            sign_reg   <= 1'b0;
            lead_reg   <= 1'b0;
            left_reg   <= '0;
        end else begin
            active_reg <= active_next;
            valid_reg  <= valid_next;
            sign_reg   <= sign_next;
            lead_reg   <= lead_next;
            left_reg   <= left_next;
        end
        dig_reg  <= dig_next;
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign stat.busy   = active_reg;
    assign stat.finish = push_dig && is_final;
    assign m_tvalid    = valid_reg;
    assign m_tdata     = data_reg;
    assign m_tlast     = last_reg;

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// signed_int_to_decimal_ascii: top level, signed integer to decimal text.
// Depends on itoa_pkg, itoa_dabble and itoa_emit.
//
// Usage:
//   Slave channel (s_t*): one item is one two's-complement integer; only the
//   low VALUE_WIDTH bits of s_tdata count, bit VALUE_WIDTH-1 is the sign.
//   Master channel (m_t*): one item per ASCII character: '-' first for a
//   negative number, then the digits most significant first, no leading
//   zeros (zero gives "0"). m_tlast marks the final digit of each number.
//   Timing: after an item is taken, the magnitude goes through the
//   double-dabble unit, 4 bits per cycle. The emitter then walks the NDIG
//   digit slots (10 at 32 bits) one per cycle while the receiver does not
//   stall; a leading zero is dropped with no output, and a minus sign goes
//   out alongside a dropped zero or else on its own ahead of the first digit.
//   A new item is taken only once the final digit of the last one has
//   entered the output register.
//   s_tready is high only while idle; the last character may still sit in
//   the output register while the next number is taken.
//   Stalls: a low m_tready holds the current character; digit walking stops
//   until the output register frees, skipped zeros still advance.
//   Reset (aresetn low, synchronous): drops any number in flight and any
//   pending character; the block comes back idle and ready.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32,
    localparam int TDATA_W    = ((VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // [VALUE_WIDTH-1:0] value, rest zero
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] character
    output logic               m_tlast
);

    // Digit slots: enough for 2^(VALUE_WIDTH-1).
    localparam int NDIG = (VALUE_WIDTH * 3) / 10 + 1;
    localparam int BCDW = NDIG * itoa_pkg::DIGIT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   neg_reg, neg_next;

    logic                   accept;
    logic [VALUE_WIDTH-1:0] raw;
    logic                   raw_neg;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   conv_done;
    logic [BCDW-1:0]        bcd;
    itoa_pkg::emit_cmd_t    emit_cmd;
    itoa_pkg::emit_stat_t   emit_stat;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Magnitude in VALUE_WIDTH bits; the most negative value maps to
    // 2^(VALUE_WIDTH-1), which still fits unsigned.
    assign raw     = s_tdata[VALUE_WIDTH-1:0];
    assign raw_neg = raw[VALUE_WIDTH-1];
    assign mag     = raw_neg ? ((~raw) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        emit_cmd.load = 1'b0;
        emit_cmd.neg  = neg_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next   = raw_neg;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_done) begin
                    emit_cmd.load = 1'b1;
                    state_next    = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit_stat.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        neg_reg <= neg_next;
    end

    itoa_dabble #(
        .VALUE_WIDTH(VALUE_WIDTH),
        .NDIG       (NDIG)
    ) u_dabble (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (accept),
        .mag    (mag),
        .done   (conv_done),
        .bcd    (bcd)
    );

    itoa_emit #(
        .NDIG(NDIG)
    ) u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (emit_cmd),
        .bcd     (bcd),
        .stat    (emit_stat),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // The emitter stays quiet while a conversion runs.
    a_emit_idle_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CONV) |-> !emit_stat.busy)
        else $error("emitter busy during conversion");

    // Conversion finishes only while the sequencer waits for it.
    a_done_in_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_done |-> (state_reg == ST_CONV))
        else $error("conversion done outside conversion state");

    // A minus sign never closes a number.
    a_minus_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata == itoa_pkg::CHAR_MINUS)) |-> !m_tlast)
        else $error("minus sign flagged last");

    // Every other character is a decimal digit.
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata != itoa_pkg::CHAR_MINUS)) |->
        ((m_tdata >= itoa_pkg::CHAR_ZERO) &&
         (m_tdata <= (itoa_pkg::CHAR_ZERO + {4'b0000, itoa_pkg::DIGIT_MAX}))))
        else $error("character out of digit range");

endmodule
